/* hdl/sdr_pkg.sv */
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants of the SDI-12 frame receiver: channel payloads,
// configuration register map, receiver phases and result kinds.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // run counter width, default for the top level parameter
  localparam int COUNT_BITS_DEF = 32;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CHAR_W    = 7;
  localparam int DUR_W     = 32;
  localparam int BIT_IDX_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLES         = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SAMPLE_OFFSET = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MIN_SAMPLES   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MAX_SAMPLES   = CFG_IDX_W'(3);

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] BIT_SAMPLES_RST         = CFG_W'(833);
  localparam logic [CFG_W-1:0] FIRST_SAMPLE_OFFSET_RST = CFG_W'(1250);
  localparam logic [CFG_W-1:0] BREAK_MIN_SAMPLES_RST   = CFG_W'(11600);
  localparam logic [CFG_W-1:0] BREAK_MAX_SAMPLES_RST   = CFG_W'(12400);

  // result kinds
  localparam logic [1:0] FK_DATA  = 2'd0;
  localparam logic [1:0] FK_BREAK = 2'd1;
  localparam logic [1:0] FK_MARK  = 2'd2;

  // index of the parity bit; data bits come before it, stop bit after
  localparam logic [BIT_IDX_W-1:0] PARITY_IDX = BIT_IDX_W'(CHAR_W);
  localparam logic [BIT_IDX_W-1:0] STOP_IDX   = BIT_IDX_W'(CHAR_W + 1);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_CHAR = 2'd1,
    PH_HELD = 2'd2,
    PH_MARK = 2'd3
  } phase_t;

  typedef struct packed {
    logic line_level;
  } sdr_in_t;

  typedef struct packed {
    logic [1:0]        frame_kind;
    logic [CHAR_W-1:0] char_value;
    logic              parity_fail;
    logic              stop_fail;
    logic [DUR_W-1:0]  duration;
  } sdr_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     wdata;
  } sdr_cfg_wr_t;

  typedef struct packed {
    logic [CFG_W-1:0] bit_samples;
    logic [CFG_W-1:0] first_sample_offset;
    logic [CFG_W-1:0] break_min_samples;
    logic [CFG_W-1:0] break_max_samples;
  } sdr_cfg_t;

endpackage

/* hdl/sdr_chan_if.sv */
// ----------------------------------------------------------------------------
// sdr_chan_if
// Valid/ready channel carrying one payload of a configurable type.
// ----------------------------------------------------------------------------
interface sdr_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* hdl/sdr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sdr_cfg_regs
// Configuration register file: bit timing and break window, written by index.
// ----------------------------------------------------------------------------
module sdr_cfg_regs
  import sdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  sdr_cfg_wr_t wr,
  output sdr_cfg_t    cfg
);

  sdr_cfg_t cfg_r;
  sdr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr.reg_index)
        REG_BIT_SAMPLES:         cfg_nxt.bit_samples         = wr.wdata;
        REG_FIRST_SAMPLE_OFFSET: cfg_nxt.first_sample_offset = wr.wdata;
        REG_BREAK_MIN_SAMPLES:   cfg_nxt.break_min_samples   = wr.wdata;
        REG_BREAK_MAX_SAMPLES:   cfg_nxt.break_max_samples   = wr.wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_samples         <= BIT_SAMPLES_RST;
      cfg_r.first_sample_offset <= FIRST_SAMPLE_OFFSET_RST;
      cfg_r.break_min_samples   <= BREAK_MIN_SAMPLES_RST;
      cfg_r.break_max_samples   <= BREAK_MAX_SAMPLES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/sdr_decoder.sv */
// ----------------------------------------------------------------------------
// sdr_decoder
// Sample register followed by the receiver state machine: edge detection,
// run timing for break and marking, bit sampling, parity and stop checks.
// ----------------------------------------------------------------------------
module sdr_decoder
  import sdr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_level,
  output logic        in_ready,
  input  sdr_cfg_t    cfg,
  input  logic        res_free,
  output logic        res_valid,
  output sdr_result_t res
);

  localparam int CMP_W = (COUNT_BITS > DUR_W) ? COUNT_BITS : DUR_W;
  localparam logic [CMP_W-1:0] DUR_MAX = CMP_W'({DUR_W{1'b1}});

  // sample register
  logic stage_valid_r;
  logic stage_level_r;

  // receiver state
  phase_t                phase_r, phase_nxt;
  logic                  last_level_r, last_level_nxt;
  logic [COUNT_BITS-1:0] run_r, run_nxt;
  logic [CFG_W-1:0]      cnt_r, cnt_nxt;
  logic [BIT_IDX_W-1:0]  bit_idx_r, bit_idx_nxt;
  logic [CHAR_W-1:0]     shift_r, shift_nxt;
  logic                  parity_bad_r, parity_bad_nxt;
  logic                  chk_off_r, chk_off_nxt;

  logic                  lvl;
  logic                  rising;
  logic                  fire;
  logic [CMP_W-1:0]      run_ext;
  logic                  in_win;
  logic [COUNT_BITS-1:0] run_inc;
  logic [CFG_W-1:0]      bit_reload;
  logic [CFG_W-1:0]      first_reload;
  logic                  chk_eff;
  logic                  char_brk;
  logic                  due;
  logic                  stop_step;
  logic                  char_hold;
  logic                  char_done;
  logic                  held_brk;
  logic                  held_done;
  logic                  mark_end;
  logic [DUR_W-1:0]      run_dur;

  assign lvl    = stage_level_r;
  assign rising = lvl && !last_level_r;

  assign run_ext = CMP_W'(run_r);
  assign in_win  = (run_ext >= CMP_W'(cfg.break_min_samples)) &&
                   (run_ext <= CMP_W'(cfg.break_max_samples));
  assign run_inc = (run_r == {COUNT_BITS{1'b1}}) ? run_r : run_r + COUNT_BITS'(1);
  assign run_dur = (run_ext > DUR_MAX) ? {DUR_W{1'b1}} : run_ext[DUR_W-1:0];

  // zero timing registers behave as one
  assign bit_reload   = (cfg.bit_samples == '0) ? CFG_W'(1) : cfg.bit_samples;
  assign first_reload = (cfg.first_sample_offset == '0) ? CFG_W'(1)
                                                         : cfg.first_sample_offset;

  // event decode for the current sample
  assign char_brk  = (phase_r == PH_CHAR) && !chk_off_r && !lvl && in_win;
  assign chk_eff   = chk_off_r || !lvl;
  assign due       = (cnt_r <= CFG_W'(1));
  assign stop_step = (phase_r == PH_CHAR) && !char_brk && due && (bit_idx_r >= STOP_IDX);
  assign char_hold = stop_step && lvl && !chk_eff;
  assign char_done = stop_step && !char_hold;
  assign held_brk  = (phase_r == PH_HELD) && !lvl && in_win;
  assign held_done = (phase_r == PH_HELD) && !lvl && !in_win;
  assign mark_end  = (phase_r == PH_MARK) && lvl;

  // result block
  always_comb begin
    res_valid        = 1'b0;
    res.frame_kind   = FK_DATA;
    res.char_value   = '0;
    res.parity_fail  = 1'b0;
    res.stop_fail    = 1'b0;
    res.duration     = '0;
    case (phase_r)
      PH_CHAR: begin
        if (char_brk) begin
          res_valid      = 1'b1;
          res.frame_kind = FK_BREAK;
          res.duration   = run_dur;
        end else if (char_done) begin
          res_valid       = 1'b1;
          res.char_value  = shift_r;
          res.parity_fail = parity_bad_r;
          res.stop_fail   = lvl;
        end
      end
      PH_HELD: begin
        if (held_brk) begin
          res_valid      = 1'b1;
          res.frame_kind = FK_BREAK;
          res.duration   = run_dur;
        end else if (held_done) begin
          res_valid       = 1'b1;
          res.char_value  = shift_r;
          res.parity_fail = parity_bad_r;
          res.stop_fail   = 1'b1;
        end
      end
      PH_MARK: begin
        if (mark_end) begin
          res_valid      = 1'b1;
          res.frame_kind = FK_MARK;
          res.duration   = run_dur;
        end
      end
      default: res_valid = 1'b0;
    endcase
    // an empty sample register gives no result
    if (!stage_valid_r) begin
      res_valid = 1'b0;
    end
  end

  // the sample is consumed unless its result would hit a full output slot
  assign fire     = stage_valid_r && (!res_valid || res_free);
  assign in_ready = !stage_valid_r || fire;

  // next state block
  always_comb begin
    phase_nxt      = phase_r;
    last_level_nxt = lvl;
    run_nxt        = run_r;
    cnt_nxt        = cnt_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    parity_bad_nxt = parity_bad_r;
    chk_off_nxt    = chk_off_r;
    case (phase_r)
      PH_CHAR: begin
        if (char_brk) begin
          phase_nxt = PH_MARK;
          run_nxt   = COUNT_BITS'(1);
        end else begin
          if (!chk_off_r) begin
            chk_off_nxt = chk_eff;
            if (lvl) begin
              run_nxt = run_inc;
            end
          end
          if (!due) begin
            cnt_nxt = cnt_r - CFG_W'(1);
          end else begin
            cnt_nxt = bit_reload;
            if (bit_idx_r < PARITY_IDX) begin
              // low on the line reads as one
              shift_nxt[bit_idx_r[2:0]] = !lvl;
              bit_idx_nxt = bit_idx_r + BIT_IDX_W'(1);
            end else if (bit_idx_r == PARITY_IDX) begin
              parity_bad_nxt = (^shift_r) ^ !lvl;
              bit_idx_nxt    = STOP_IDX;
            end else if (char_hold) begin
              phase_nxt = PH_HELD;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end
        end
      end
      PH_HELD: begin
        if (lvl) begin
          run_nxt = run_inc;
        end else if (in_win) begin
          phase_nxt = PH_MARK;
          run_nxt   = COUNT_BITS'(1);
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_MARK: begin
        if (!lvl) begin
          run_nxt = run_inc;
        end else begin
          // edge that ends marking starts a character with no break check
          phase_nxt      = PH_CHAR;
          chk_off_nxt    = 1'b1;
          run_nxt        = COUNT_BITS'(1);
          cnt_nxt        = first_reload;
          bit_idx_nxt    = '0;
          shift_nxt      = '0;
          parity_bad_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
        if (rising) begin
          phase_nxt      = PH_CHAR;
          chk_off_nxt    = 1'b0;
          run_nxt        = COUNT_BITS'(1);
          cnt_nxt        = first_reload;
          bit_idx_nxt    = '0;
          shift_nxt      = '0;
          parity_bad_nxt = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_level_r <= in_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      last_level_r <= 1'b0;
      run_r        <= '0;
      cnt_r        <= '0;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      parity_bad_r <= 1'b0;
      chk_off_r    <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      last_level_r <= last_level_nxt;
      run_r        <= run_nxt;
      cnt_r        <= cnt_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      parity_bad_r <= parity_bad_nxt;
      chk_off_r    <= chk_off_nxt;
    end
  end

  // a held character only exists while the break check is still armed
  a_held_armed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HELD |-> !chk_off_r)
    else $error("held character with break check off");

  a_mark_start: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_MARK && lvl |=> phase_r == PH_CHAR && chk_off_r)
    else $error("end of marking did not start an unchecked character");

  a_bit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHAR |-> bit_idx_r <= STOP_IDX)
    else $error("bit index past stop bit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !fire |=> stage_valid_r && $stable(stage_level_r) &&
                               $stable(phase_r) && $stable(run_r))
    else $error("stalled sample or state changed");

endmodule

/* hdl/sdr_out_reg.sv */
// ----------------------------------------------------------------------------
// sdr_out_reg
// Result register between the decoder and the result channel.
// ----------------------------------------------------------------------------
module sdr_out_reg
  import sdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  sdr_result_t load_data,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output sdr_result_t out_data
);

  logic        valid_r;
  logic        valid_nxt;
  sdr_result_t data_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |-> !load)
    else $error("result overwritten while waiting");

endmodule

/* hdl/sdr12_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sdi12_frame_receiver
// SDI-12 receiver on an inverted line: 7 data bits, even parity, one stop
// bit, with break and marking detection. One line sample per request.
// ----------------------------------------------------------------------------
//   channel   dir   payload                                          request
//   in_chan   in    line_level                                       one sample
//   out_chan  out   frame_kind, char_value, parity_fail,             one frame
//                   stop_fail, duration
//   cfg_chan  in    reg_index, wdata                                 register write
//
// One sample is taken per clock while no stalled result holds the sample
// register; a sample goes through the sample register and then the state
// update, which loads its result into the result register.
// Reset (rst_n low, synchronous) restores register defaults and waits for
// a rising edge. A stalled result holds the sample register; further
// samples are refused only once both the result register and the sample
// register are occupied. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module sdi12_frame_receiver
  import sdr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sdr_chan_if.sink   in_chan,
  sdr_chan_if.source out_chan,
  sdr_chan_if.sink   cfg_chan
);

  sdr_cfg_t    cfg;
  sdr_result_t res;
  logic        res_valid;
  logic        res_free;
  logic        in_ready;

  assign cfg_chan.ready = 1'b1;

  sdr_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_chan.valid),
    .wr    (cfg_chan.payload),
    .cfg   (cfg)
  );

  sdr_decoder #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_level  (in_chan.payload.line_level),
    .in_ready  (in_ready),
    .cfg       (cfg),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_chan.ready = in_ready;

  sdr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid && res_free),
    .load_data (res),
    .free      (res_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.payload)
  );

endmodule
